// ===== rtl/core/rational_arithmetic_unit_assert.svh =====
// Assertion macros for the rational arithmetic unit.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define RAU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rau assertion failed");

// Next-cycle implication, disabled during reset
`define RAU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rau assertion failed");

`endif

// ===== rtl/core/rau_pkg.sv =====
// Shared types, constants and the microcode table of the rational arithmetic unit.
// No dependencies.
`default_nettype none

package rau_pkg;

  localparam int RES_NUM_W = 34;
  localparam int RES_DEN_W = 31;
  localparam int STEP_W    = 5;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_code_t;

  typedef logic [STEP_W-1:0] step_t;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_GCD_INIT,
    DP_GCD_SUB,
    DP_DIVA_INIT,
    DP_DIV_STEP,
    DP_DIVB_INIT,
    DP_MUL_L,
    DP_MUL_TA,
    DP_MUL_TB,
    DP_ADD_SUB,
    DP_MUL_NUM,
    DP_MUL_DEN,
    DP_DIV_NUM,
    DP_DIV_DEN
  } dp_op_t;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_OP_MUL,
    C_OP_DIV,
    C_GCD_NE,
    C_CNT_MORE
  } cond_t;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
    logic   last;
  } uword_t;

  typedef struct packed {
    logic op_mul;
    logic op_div;
    logic gcd_ne;
    logic cnt_more;
  } dp_status_t;

  // Program entry points
  localparam step_t ST_IDLE = 5'd0;
  localparam step_t ST_GCD  = 5'd3;
  localparam step_t ST_DIVA = 5'd5;
  localparam step_t ST_DIVB = 5'd7;
  localparam step_t ST_MUL  = 5'd12;
  localparam step_t ST_DIV  = 5'd14;
  localparam step_t ST_DONE = 5'd16;

  // Microcode ROM
  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      5'd0:    w = '{DP_LOAD,      C_NO_ACCEPT, ST_IDLE, 1'b0};
      5'd1:    w = '{DP_GCD_INIT,  C_OP_MUL,    ST_MUL,  1'b0};
      5'd2:    w = '{DP_NOP,       C_OP_DIV,    ST_DIV,  1'b0};
      5'd3:    w = '{DP_GCD_SUB,   C_GCD_NE,    ST_GCD,  1'b0};
      5'd4:    w = '{DP_DIVA_INIT, C_NONE,      ST_IDLE, 1'b0};
      5'd5:    w = '{DP_DIV_STEP,  C_CNT_MORE,  ST_DIVA, 1'b0};
      5'd6:    w = '{DP_DIVB_INIT, C_NONE,      ST_IDLE, 1'b0};
      5'd7:    w = '{DP_DIV_STEP,  C_CNT_MORE,  ST_DIVB, 1'b0};
      5'd8:    w = '{DP_MUL_L,     C_NONE,      ST_IDLE, 1'b0};
      5'd9:    w = '{DP_MUL_TA,    C_NONE,      ST_IDLE, 1'b0};
      5'd10:   w = '{DP_MUL_TB,    C_NONE,      ST_IDLE, 1'b0};
      5'd11:   w = '{DP_ADD_SUB,   C_ALWAYS,    ST_DONE, 1'b0};
      5'd12:   w = '{DP_MUL_NUM,   C_NONE,      ST_IDLE, 1'b0};
      5'd13:   w = '{DP_MUL_DEN,   C_ALWAYS,    ST_DONE, 1'b0};
      5'd14:   w = '{DP_DIV_NUM,   C_NONE,      ST_IDLE, 1'b0};
      5'd15:   w = '{DP_DIV_DEN,   C_NONE,      ST_IDLE, 1'b0};
      5'd16:   w = '{DP_NOP,       C_NONE,      ST_IDLE, 1'b1};
      default: w = '{DP_NOP,       C_ALWAYS,    ST_IDLE, 1'b0};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rau_seq.sv =====
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on rau_pkg.
`default_nettype none

module rau_seq
  import rau_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       out_free,
  input  wire dp_status_t status,
  output uword_t          uw,
  output logic            idle
);

  step_t step_r, step_nxt;
  logic  hit;

  assign uw   = ucode(step_r);
  assign idle = (step_r == ST_IDLE);

  // Evaluate the jump condition and pick the next step
  always_comb begin
    case (uw.cond)
      C_NONE:      hit = 1'b0;
      C_ALWAYS:    hit = 1'b1;
      C_NO_ACCEPT: hit = !accept;
      C_OP_MUL:    hit = status.op_mul;
      C_OP_DIV:    hit = status.op_div;
      C_GCD_NE:    hit = status.gcd_ne;
      C_CNT_MORE:  hit = status.cnt_more;
      default:     hit = 1'b0;
    endcase
    if (uw.last) begin
      step_nxt = out_free ? ST_IDLE : step_r;
    end else if (hit) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + 1'b1;
    end
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rau_dp.sv =====
// Datapath: operand normalize, subtractive GCD, restoring divider, shared multiplier.
// Depends on rau_pkg; driven by rau_seq control words.
`default_nettype none

module rau_dp
  import rau_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic                        clk,
  input  wire dp_op_t                      dp_op,
  input  wire logic                        in_en,
  input  wire logic [1:0]                  in_op,
  input  wire logic signed [W-1:0]         in_a_num,
  input  wire logic signed [W-1:0]         in_a_den,
  input  wire logic signed [W-1:0]         in_b_num,
  input  wire logic signed [W-1:0]         in_b_den,
  output dp_status_t                       status,
  output logic signed [RES_NUM_W-1:0]      res_num,
  output logic [RES_DEN_W-1:0]             res_den,
  output logic                             res_dz
);

  localparam int CW = $clog2(W + 1);
  localparam logic [CW-1:0] CNT_INIT = CW'(W);

  op_code_t                     op_r;
  logic signed [W:0]            an_r, bn_r;
  logic [W-1:0]                 ad_r, bd_r;
  logic [W-1:0]                 x_r, y_r;
  logic [W-1:0]                 rem_r, quo_r;
  logic [W-1:0]                 fa_r, fb_r;
  logic [CW-1:0]                cnt_r;
  logic signed [RES_NUM_W-1:0]  num_r, tb_r;
  logic [RES_DEN_W-1:0]         den_r;
  logic                         dz_r;

  logic signed [W:0]            an_n, bn_n, ad_n, bd_n;
  logic [W:0]                   r2, r2_diff;
  logic                         ge;
  logic [W-1:0]                 rem_nxt;
  logic                         bn_neg;
  logic signed [W:0]            ma, mb;
  logic signed [2*W+1:0]        prod;
  logic signed [63:0]           prod_w;

  // Normalize a fraction: zero denominator reads as one, negative flips both signs
  function automatic logic [2*W+1:0] normalize(logic [W-1:0] n, logic [W-1:0] d);
    logic signed [W:0] ns;
    logic signed [W:0] ds;
    ns = {n[W-1], n};
    ds = {d[W-1], d};
    if (ds == '0) begin
      ds = (W+1)'(1);
    end
    if (ds[W]) begin
      ns = -ns;
      ds = -ds;
    end
    return {ns, ds};
  endfunction

  always_comb begin
    {an_n, ad_n} = normalize(in_a_num, in_a_den);
    {bn_n, bd_n} = normalize(in_b_num, in_b_den);
  end

  // One restoring division step; divisor is the GCD held in x_r
  always_comb begin
    r2      = {rem_r, quo_r[W-1]};
    r2_diff = r2 - {1'b0, x_r};
    ge      = (r2 >= {1'b0, x_r});
    rem_nxt = ge ? r2_diff[W-1:0] : r2[W-1:0];
  end

  // Select multiplier operands per control word
  assign bn_neg = bn_r[W];

  always_comb begin
    case (dp_op)
      DP_MUL_L: begin
        ma = $signed({1'b0, fb_r});
        mb = $signed({1'b0, bd_r});
      end
      DP_MUL_TA: begin
        ma = an_r;
        mb = $signed({1'b0, fa_r});
      end
      DP_MUL_TB: begin
        ma = bn_r;
        mb = $signed({1'b0, fb_r});
      end
      DP_MUL_NUM: begin
        ma = an_r;
        mb = bn_r;
      end
      DP_MUL_DEN: begin
        ma = $signed({1'b0, ad_r});
        mb = $signed({1'b0, bd_r});
      end
      DP_DIV_NUM: begin
        ma = bn_neg ? -an_r : an_r;
        mb = $signed({1'b0, bd_r});
      end
      DP_DIV_DEN: begin
        ma = $signed({1'b0, ad_r});
        mb = bn_neg ? -bn_r : bn_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod   = ma * mb;
  assign prod_w = 64'(prod);

  // Execute the current control word
  always_ff @(posedge clk) begin
    case (dp_op)
      DP_LOAD: begin
        if (in_en) begin
          op_r <= op_code_t'(in_op);
          an_r <= an_n;
          ad_r <= ad_n[W-1:0];
          bn_r <= bn_n;
          bd_r <= bd_n[W-1:0];
          dz_r <= 1'b0;
        end
      end
      DP_GCD_INIT: begin
        x_r <= ad_r;
        y_r <= bd_r;
      end
      DP_GCD_SUB: begin
        if (x_r > y_r) begin
          x_r <= x_r - y_r;
        end else if (y_r > x_r) begin
          y_r <= y_r - x_r;
        end
      end
      DP_DIVA_INIT: begin
        rem_r <= '0;
        quo_r <= ad_r;
        cnt_r <= CNT_INIT;
      end
      DP_DIV_STEP: begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
      end
      DP_DIVB_INIT: begin
        fb_r  <= quo_r;
        rem_r <= '0;
        quo_r <= bd_r;
        cnt_r <= CNT_INIT;
      end
      DP_MUL_L: begin
        fa_r  <= quo_r;
        den_r <= prod_w[RES_DEN_W-1:0];
      end
      DP_MUL_TA: begin
        num_r <= prod_w[RES_NUM_W-1:0];
      end
      DP_MUL_TB: begin
        tb_r <= prod_w[RES_NUM_W-1:0];
      end
      DP_ADD_SUB: begin
        num_r <= (op_r == OP_SUB) ? num_r - tb_r : num_r + tb_r;
      end
      DP_MUL_NUM: begin
        num_r <= prod_w[RES_NUM_W-1:0];
      end
      DP_MUL_DEN: begin
        den_r <= prod_w[RES_DEN_W-1:0];
      end
      DP_DIV_NUM: begin
        num_r <= prod_w[RES_NUM_W-1:0];
      end
      DP_DIV_DEN: begin
        den_r <= prod_w[RES_DEN_W-1:0];
        dz_r  <= (bn_r == '0);
      end
      default: begin
      end
    endcase
  end

  // Report status for jumps and expose results
  always_comb begin
    status.op_mul   = (op_r == OP_MUL);
    status.op_div   = (op_r == OP_DIV);
    status.gcd_ne   = (x_r != y_r);
    status.cnt_more = (cnt_r != CW'(1));
  end

  assign res_num = num_r;
  assign res_den = den_r;
  assign res_dz  = dz_r;

endmodule

`default_nettype wire

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: handshakes and output register.
// Depends on rau_pkg, rau_seq, rau_dp and rational_arithmetic_unit_assert.svh.
//
//   channel | ports                                                      | direction
//   in      | in_valid in_ready in_op in_a_num in_a_den in_b_num in_b_den | into block
//   out     | out_valid out_ready out_res_num out_res_den out_div_zero    | out of block
//
// One item at a time. Multiply and divide form the result numerator and then its
// denominator with the shared multiplier; add/subtract runs the GCD subtract loop on
// the denominators, two bit-per-cycle divisions by the GCD, multiplies for the common
// denominator and both scaled numerators, and then the final add or subtract.
// A new item is taken the cycle after the result loads, even while it waits.
// A stalled output holds the sequencer on its final step. Reset clears the
// step counter and the output valid flag.
`default_nettype none
`include "rational_arithmetic_unit_assert.svh"

module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [1:0]                      in_op,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_a_den,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_b_den,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [RES_NUM_W-1:0]          out_res_num,
  output logic [RES_DEN_W-1:0]                 out_res_den,
  output logic                                 out_div_zero
);

  uword_t                       seq_uw;
  dp_status_t                   dp_status;
  logic                         seq_idle;
  logic                         in_accept;
  logic                         out_free;
  logic signed [RES_NUM_W-1:0]  dp_num;
  logic [RES_DEN_W-1:0]         dp_den;
  logic                         dp_dz;

  logic                         out_valid_r;
  logic signed [RES_NUM_W-1:0]  out_res_num_r;
  logic [RES_DEN_W-1:0]         out_res_den_r;
  logic                         out_div_zero_r;

  assign in_ready  = seq_idle;
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  rau_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .out_free (out_free),
    .status   (dp_status),
    .uw       (seq_uw),
    .idle     (seq_idle)
  );

  rau_dp #(
    .W (OPERAND_WIDTH)
  ) u_dp (
    .clk      (clk),
    .dp_op    (seq_uw.op),
    .in_en    (in_accept),
    .in_op    (in_op),
    .in_a_num (in_a_num),
    .in_a_den (in_a_den),
    .in_b_num (in_b_num),
    .in_b_den (in_b_den),
    .status   (dp_status),
    .res_num  (dp_num),
    .res_den  (dp_den),
    .res_dz   (dp_dz)
  );

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq_uw.last && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_uw.last && out_free) begin
      out_res_num_r  <= dp_num;
      out_res_den_r  <= dp_den;
      out_div_zero_r <= dp_dz;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_res_num  = out_res_num_r;
  assign out_res_den  = out_res_den_r;
  assign out_div_zero = out_div_zero_r;

  // Checks
  `RAU_ASSERT_IMP(a_dz_den_zero, out_valid_r && out_div_zero_r, out_res_den_r == '0)
  `RAU_ASSERT_NXT(a_load_sets_valid, seq_uw.last && out_free, out_valid_r)
  `RAU_ASSERT_NXT(a_accept_leaves_idle, in_accept, !in_ready)

endmodule

`default_nettype wire
